// ----- rtl/vtpd_pkg.sv -----
`default_nettype none
package vtpd_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DATA_W     = 32;
  localparam int COEF_W     = 64;
  localparam int NUM_REGS   = 8;
  localparam int CFG_IDX_W  = $clog2(NUM_REGS);
  localparam int NUM_ROWS   = 4;

  localparam int PROD_W     = 2 * DATA_W;
  localparam int TRUNC_W    = PROD_W - FRAC_BITS;
  localparam int SUM_W      = TRUNC_W + 2;

  localparam int DVD_W      = DATA_W + FRAC_BITS;
  localparam int DIV_STEP   = 4;
  localparam int DIV_STAGES = (DVD_W + DIV_STEP - 1) / DIV_STEP;
  localparam int DVD_PAD_W  = DIV_STAGES * DIV_STEP;

  localparam int ROW_LAT    = 3;
  localparam int DIV_LAT    = DIV_STAGES + 2;
  localparam int TOT_LAT    = ROW_LAT + DIV_LAT + 1;

  localparam int IN_W       = 6 * DATA_W;
  localparam int NORM_W     = 3 * DATA_W;
  localparam int USER_W     = 2;

  localparam int USER_WZERO = 0;
  localparam int USER_OVF   = 1;

  typedef logic signed [DATA_W-1:0] fx_t;

  typedef struct packed {
    fx_t  ax;
    fx_t  ay;
    fx_t  az;
    logic wzero;
    logic ovf;
  } side_t;

endpackage
`default_nettype wire

// ----- rtl/vertex_transform_perspective_divide_unit.sv -----
// Transforms one vertex per clock by a 4x4 Q16.16 matrix and divides x, y, z by w.
// Each beat passes through the multiply and row sum registers, the pipelined divider
// (four quotient bits per stage) and one output register. A new beat is taken every
// cycle; when the output is held, the whole pipeline holds with it. The normal rides
// along unchanged; w_was_zero marks beats passed on undivided. Matrix writes are
// taken at any time and land at once.
`default_nettype none
module vertex_transform_perspective_divide_unit
  import vtpd_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [IN_W-1:0]      in_tdata,   // x, y, z, norm_x, norm_y, norm_z
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [IN_W-1:0]           out_tdata,  // x, y, z, norm_x, norm_y, norm_z
  output logic [USER_W-1:0]         out_tuser,  // w_was_zero, overflow
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [COEF_W-1:0]    cfg_data
);

  logic [COEF_W-1:0] coef_r [NUM_REGS];
  logic              vld_r  [TOT_LAT];
  logic [NORM_W-1:0] nrm_r  [ROW_LAT+DIV_LAT];
  side_t             side_r [DIV_LAT];
  logic              ce;
  fx_t               sum   [NUM_ROWS];
  logic              rovf  [NUM_ROWS];
  fx_t               q     [3];
  logic              qovf  [3];
  side_t             side_nxt, sd;
  logic [IN_W-1:0]   out_tdata_r;
  logic [USER_W-1:0] out_tuser_r;

  assign ce        = out_tready || !vld_r[TOT_LAT-1];
  assign in_tready = ce;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) coef_r[i] <= '0;
    end else if (cfg_valid) begin
      coef_r[cfg_index] <= cfg_data;
    end
  end

  for (genvar r = 0; r < NUM_ROWS; r++) begin : g_row
    vtpd_row_mac u_row (
      .clk (clk),
      .ce  (ce),
      .x   (in_tdata[DATA_W-1:0]),
      .y   (in_tdata[2*DATA_W-1:DATA_W]),
      .z   (in_tdata[3*DATA_W-1:2*DATA_W]),
      .c0  (coef_r[2*r][DATA_W-1:0]),
      .c1  (coef_r[2*r][COEF_W-1:DATA_W]),
      .c2  (coef_r[2*r+1][DATA_W-1:0]),
      .c3  (coef_r[2*r+1][COEF_W-1:DATA_W]),
      .sum (sum[r]),
      .ovf (rovf[r])
    );
  end

  for (genvar k = 0; k < 3; k++) begin : g_div
    vtpd_div_pipe u_div (
      .clk (clk),
      .ce  (ce),
      .num (sum[k]),
      .den (sum[NUM_ROWS-1]),
      .quo (q[k]),
      .ovf (qovf[k])
    );
  end

  always_comb begin
    side_nxt.ax    = sum[0];
    side_nxt.ay    = sum[1];
    side_nxt.az    = sum[2];
    side_nxt.wzero = (sum[NUM_ROWS-1] == '0);
    side_nxt.ovf   = rovf[0] | rovf[1] | rovf[2] | rovf[3];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TOT_LAT; i++) vld_r[i] <= 1'b0;
    end else if (ce) begin
      vld_r[0] <= in_tvalid;
      for (int i = 1; i < TOT_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      nrm_r[0] <= in_tdata[IN_W-1:3*DATA_W];
      for (int i = 1; i < ROW_LAT+DIV_LAT; i++) nrm_r[i] <= nrm_r[i-1];
      side_r[0] <= side_nxt;
      for (int i = 1; i < DIV_LAT; i++) side_r[i] <= side_r[i-1];
    end
  end

  assign sd = side_r[DIV_LAT-1];

  always_ff @(posedge clk) begin
    if (ce) begin
      out_tdata_r[IN_W-1:3*DATA_W] <= nrm_r[ROW_LAT+DIV_LAT-1];
      if (sd.wzero) begin
        out_tdata_r[3*DATA_W-1:0] <= {sd.az, sd.ay, sd.ax};
        out_tuser_r[USER_OVF]     <= sd.ovf;
      end else begin
        out_tdata_r[3*DATA_W-1:0] <= {q[2], q[1], q[0]};
        out_tuser_r[USER_OVF]     <= sd.ovf | qovf[0] | qovf[1] | qovf[2];
      end
      out_tuser_r[USER_WZERO] <= sd.wzero;
    end
  end

  assign out_tvalid = vld_r[TOT_LAT-1];
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule
`default_nettype wire

// ----- rtl/vtpd_row_mac.sv -----
`default_nettype none
module vtpd_row_mac
  import vtpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic ce,
  input  wire fx_t  x,
  input  wire fx_t  y,
  input  wire fx_t  z,
  input  wire fx_t  c0,
  input  wire fx_t  c1,
  input  wire fx_t  c2,
  input  wire fx_t  c3,
  output fx_t       sum,
  output logic      ovf
);

  logic signed [PROD_W-1:0]  p0_r, p1_r, p2_r;
  fx_t                       c3_r, c3b_r;
  logic signed [TRUNC_W-1:0] t0_r, t1_r, t2_r;
  logic signed [TRUNC_W-1:0] t0_nxt, t1_nxt, t2_nxt;
  logic signed [SUM_W-1:0]   s;
  fx_t                       sum_r, sum_nxt;
  logic                      ovf_r, ovf_nxt;

  function automatic logic signed [TRUNC_W-1:0] trunc0(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = p + {{(PROD_W-FRAC_BITS){1'b0}}, {FRAC_BITS{p[PROD_W-1]}}};
    return t[PROD_W-1:FRAC_BITS];
  endfunction

  always_comb begin
    t0_nxt = trunc0(p0_r);
    t1_nxt = trunc0(p1_r);
    t2_nxt = trunc0(p2_r);
    s = SUM_W'(t0_r) + SUM_W'(t1_r) + SUM_W'(t2_r) + SUM_W'(c3b_r);
    if (s[SUM_W-1:DATA_W-1] == '0 || s[SUM_W-1:DATA_W-1] == '1) begin
      sum_nxt = s[DATA_W-1:0];
      ovf_nxt = 1'b0;
    end else begin
      sum_nxt = s[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      ovf_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      p0_r  <= x * c0;
      p1_r  <= y * c1;
      p2_r  <= z * c2;
      c3_r  <= c3;
      t0_r  <= t0_nxt;
      t1_r  <= t1_nxt;
      t2_r  <= t2_nxt;
      c3b_r <= c3_r;
      sum_r <= sum_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign sum = sum_r;
  assign ovf = ovf_r;

endmodule
`default_nettype wire

// ----- rtl/vtpd_div_pipe.sv -----
`default_nettype none
module vtpd_div_pipe
  import vtpd_pkg::*;
(
  input  wire logic clk,
  input  wire logic ce,
  input  wire fx_t  num,
  input  wire fx_t  den,
  output fx_t       quo,
  output logic      ovf
);

  logic [DATA_W-1:0]    rem_r [DIV_STAGES+1];
  logic [DVD_PAD_W-1:0] dq_r  [DIV_STAGES+1];
  logic [DATA_W-1:0]    den_r [DIV_STAGES+1];
  logic                 neg_r [DIV_STAGES+1];
  logic [DATA_W-1:0]    num_mag, den_mag;
  logic [DVD_PAD_W-1:0] mag;
  logic                 big;
  fx_t                  quo_r, quo_nxt;
  logic                 ovf_r, ovf_nxt;

  always_comb begin
    num_mag = num[DATA_W-1] ? DATA_W'(-num) : DATA_W'(num);
    den_mag = den[DATA_W-1] ? DATA_W'(-den) : DATA_W'(den);
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      rem_r[0] <= '0;
      dq_r[0]  <= DVD_PAD_W'(num_mag) << FRAC_BITS;
      den_r[0] <= den_mag;
      neg_r[0] <= num[DATA_W-1] ^ den[DATA_W-1];
    end
  end

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic [DATA_W-1:0]    rem_nxt;
    logic [DVD_PAD_W-1:0] dq_nxt;
    logic [DATA_W:0]      t;

    always_comb begin
      rem_nxt = rem_r[s];
      dq_nxt  = dq_r[s];
      t       = '0;
      for (int i = 0; i < DIV_STEP; i++) begin
        t      = {rem_nxt, dq_nxt[DVD_PAD_W-1]};
        dq_nxt = dq_nxt << 1;
        if (t >= {1'b0, den_r[s]}) begin
          t         = t - {1'b0, den_r[s]};
          dq_nxt[0] = 1'b1;
        end
        rem_nxt = t[DATA_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (ce) begin
        rem_r[s+1] <= rem_nxt;
        dq_r[s+1]  <= dq_nxt;
        den_r[s+1] <= den_r[s];
        neg_r[s+1] <= neg_r[s];
      end
    end
  end

  always_comb begin
    mag = dq_r[DIV_STAGES];
    big = |mag[DVD_PAD_W-1:DATA_W];
    if (neg_r[DIV_STAGES]) begin
      ovf_nxt = big || (mag[DATA_W-1] && |mag[DATA_W-2:0]);
      quo_nxt = ovf_nxt ? {1'b1, {(DATA_W-1){1'b0}}} : DATA_W'(-mag[DATA_W-1:0]);
    end else begin
      ovf_nxt = big || mag[DATA_W-1];
      quo_nxt = ovf_nxt ? {1'b0, {(DATA_W-1){1'b1}}} : mag[DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      quo_r <= quo_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign quo = quo_r;
  assign ovf = ovf_r;

endmodule
`default_nettype wire

// ----- tb/sv/vertex_transform_perspective_divide_unit_tb.sv -----
`timescale 1ns / 100ps
`default_nettype none
module vertex_transform_perspective_divide_unit_tb;
  import vtpd_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = TOT_LAT + 10;
  localparam fx_t ONE_FX        = fx_t'(1 << FRAC_BITS);

  typedef enum logic [CFG_IDX_W-1:0] {
    ROW0_C01, ROW0_C23, ROW1_C01, ROW1_C23, ROW2_C01, ROW2_C23, ROW3_C01, ROW3_C23
  } coef_reg_e;

  typedef enum int {MTX_PERSP, MTX_SMALL, MTX_FULL, MTX_EXTREME, MTX_TINY_W} mtx_kind_e;

  typedef struct {
    fx_t x, y, z, nx, ny, nz;
  } vertex_t;

  typedef struct {
    fx_t x, y, z, nx, ny, nz;
    bit  wzero, ovf;
  } xformed_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_W-1:0]      in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [IN_W-1:0]      out_tdata;
  logic [USER_W-1:0]    out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEF_W-1:0]    cfg_data = '0;

  logic [COEF_W-1:0] coef_shadow [NUM_REGS];
  vertex_t           vertex_backlog[$];
  xformed_t          xform_expected[$];
  vertex_t           vertex_on_bus;
  int                mismatches = 0;
  int                burst_left = 0;
  int                gap_left = 0;
  bit                gaps_on = 1'b1;
  int                stall_phase = 0;
  int                idle_cycles = 0;

  vertex_transform_perspective_divide_unit u_top (
    .clk, .rst_n,
    .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint sx32(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic longint fx_mul_trunc(longint a, longint b);
    longint p;
    p = a * b;
    return (p < 0) ? -((-p) >>> FRAC_BITS) : (p >>> FRAC_BITS);
  endfunction

  function automatic longint clamp32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic xformed_t transform_vertex(vertex_t v);
    longint   acc [4];
    longint   raw, q;
    bit       ovf;
    xformed_t r;
    ovf = 1'b0;
    for (int row = 0; row < NUM_ROWS; row++) begin
      raw = fx_mul_trunc(v.x, sx32(coef_shadow[2*row][31:0]))
          + fx_mul_trunc(v.y, sx32(coef_shadow[2*row][63:32]))
          + fx_mul_trunc(v.z, sx32(coef_shadow[2*row+1][31:0]))
          + sx32(coef_shadow[2*row+1][63:32]);
      acc[row] = clamp32(raw);
      ovf |= (acc[row] != raw);
    end
    r.wzero = (acc[3] == 0);
    for (int i = 0; i < 3; i++) begin
      if (!r.wzero) begin
        raw = (acc[i] * ONE_FX) / acc[3];
        q = clamp32(raw);
        ovf |= (q != raw);
        acc[i] = q;
      end
    end
    r.x = fx_t'(acc[0]);
    r.y = fx_t'(acc[1]);
    r.z = fx_t'(acc[2]);
    r.nx = v.nx;
    r.ny = v.ny;
    r.nz = v.nz;
    r.ovf = ovf;
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("%0t: %s got %0d want %0d", $realtime, what, got, want);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready)
        xform_expected.push_back(transform_vertex(vertex_on_bus));
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (vertex_backlog.size() > 0) begin
          vertex_on_bus = vertex_backlog.pop_front();
          in_tdata <= {vertex_on_bus.nz, vertex_on_bus.ny, vertex_on_bus.nx,
                       vertex_on_bus.z, vertex_on_bus.y, vertex_on_bus.x};
          in_tvalid <= 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 24);
            gap_left = gaps_on ? $urandom_range(1, 7) : 0;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    xformed_t want;
    fx_t      got [6];
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        for (int i = 0; i < 6; i++) got[i] = out_tdata[i*DATA_W +: DATA_W];
        if (xform_expected.size() == 0) begin
          report_mismatch("unexpected beat, x", got[0], 0);
        end else begin
          want = xform_expected.pop_front();
          if (got[0] !== want.x) report_mismatch("x", got[0], want.x);
          if (got[1] !== want.y) report_mismatch("y", got[1], want.y);
          if (got[2] !== want.z) report_mismatch("z", got[2], want.z);
          if (got[3] !== want.nx) report_mismatch("norm_x", got[3], want.nx);
          if (got[4] !== want.ny) report_mismatch("norm_y", got[4], want.ny);
          if (got[5] !== want.nz) report_mismatch("norm_z", got[5], want.nz);
          if (out_tuser[USER_WZERO] !== want.wzero)
            report_mismatch("w_was_zero", out_tuser[USER_WZERO], want.wzero);
          if (out_tuser[USER_OVF] !== want.ovf)
            report_mismatch("overflow", out_tuser[USER_OVF], want.ovf);
        end
      end
      stall_phase = (stall_phase + 1) % 300;
      if (stall_phase < 80)
        out_tready <= 1'b1;
      else if (stall_phase < 200)
        out_tready <= ($urandom_range(0, 99) < 55);
      else
        out_tready <= (stall_phase % 4 == 0);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("vertex_transform_perspective_divide_unit: mismatch");
      $finish;
    end
  end

  task automatic write_coef(coef_reg_e idx, logic [COEF_W-1:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    coef_shadow[idx] = value;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_coef(mtx_kind_e kind);
    case (kind)
      MTX_SMALL:   return $urandom_range(0, 1) ? $urandom_range(0, 1 << 18)
                                               : -$urandom_range(0, 1 << 18);
      MTX_FULL:    return $urandom;
      MTX_EXTREME: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default:     return '0;
    endcase
  endfunction

  task automatic load_matrix(mtx_kind_e kind);
    logic [31:0] m [NUM_ROWS][4];
    for (int r = 0; r < NUM_ROWS; r++)
      for (int c = 0; c < 4; c++)
        m[r][c] = pick_coef(kind);
    if (kind == MTX_PERSP) begin
      for (int r = 0; r < 3; r++) m[r][r] = ONE_FX;
      m[0][3] = 32'h0001_8000;
      m[3][2] = ONE_FX;
    end else if (kind == MTX_TINY_W) begin
      m[3][0] = '0;
      m[3][1] = '0;
      m[3][2] = '0;
      m[3][3] = $urandom_range(1, 3);
    end
    for (int i = 0; i < NUM_REGS; i++)
      write_coef(coef_reg_e'(i), {m[i/2][2*(i%2)+1], m[i/2][2*(i%2)]});
  endtask

  function automatic fx_t pick_coord();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return $signed($urandom_range(0, 1 << 21)) - (1 << 20);
    if (sel < 85) return $urandom;
    case ($urandom_range(0, 6))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'hffff_ffff;
      3: return 32'h0000_0001;
      4: return ONE_FX;
      5: return -ONE_FX;
      default: return '0;
    endcase
  endfunction

  task automatic queue_vertex(fx_t x, fx_t y, fx_t z);
    vertex_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    v.nx = $urandom;
    v.ny = $urandom;
    v.nz = $urandom;
    vertex_backlog.push_back(v);
  endtask

  task automatic run_vertices(int count);
    for (int i = 0; i < count; i++) queue_vertex(pick_coord(), pick_coord(), pick_coord());
    while (vertex_backlog.size() > 0 || in_tvalid || xform_expected.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    fx_t edges [7];
    for (int i = 0; i < NUM_REGS; i++) coef_shadow[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset matrix: w is zero for every vertex
    run_vertices(100);

    load_matrix(MTX_PERSP);
    edges = '{32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff, 32'h1, ONE_FX, -ONE_FX};
    for (int i = 0; i < 7; i++) queue_vertex(edges[i], edges[(i + 3) % 7], edges[i]);
    queue_vertex(ONE_FX, ONE_FX, 32'h0);
    queue_vertex(32'h7fff_ffff, 32'h7fff_ffff, 32'h1);
    queue_vertex(32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff);
    queue_vertex(32'h0000_ffff, 32'hffff_0001, 32'h0000_ffff);
    run_vertices(300);

    gaps_on = 1'b0;
    load_matrix(MTX_SMALL);
    run_vertices(350);
    gaps_on = 1'b1;
    load_matrix(MTX_FULL);
    run_vertices(350);
    load_matrix(MTX_EXTREME);
    run_vertices(250);
    gaps_on = 1'b0;
    load_matrix(MTX_TINY_W);
    run_vertices(250);
    gaps_on = 1'b1;
    load_matrix(MTX_SMALL);
    run_vertices(250);

    if (mismatches == 0)
      $display("vertex_transform_perspective_divide_unit: match");
    else
      $display("vertex_transform_perspective_divide_unit: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
